// ----- src/apu_pkg.sv -----
// Shared types and constants for the Adam parameter update pipeline.
package apu_pkg;

   localparam int PARAM_COUNT = 4096;
   localparam int SLOT_W      = $clog2(PARAM_COUNT);
   localparam int IDX_W       = 12;
   localparam int VAL_W       = 32;
   localparam int STEP_W      = 16;
   localparam int MOM2_W      = 48;
   localparam int G2_W        = 47;
   localparam int DEN_W       = 49;
   localparam int QUO_W       = 64;
   localparam int REM2_W      = 34;
   localparam int ROOT_W      = 32;
   localparam int CFG_W       = 32;
   localparam int CSR_IDX_W   = 2;

   // cell counts of the chains
   localparam int POW_CELLS  = STEP_W;
   localparam int DIV_CELLS  = QUO_W;
   localparam int ROOT_CELLS = ROOT_W;
   localparam int STEP_CELLS = 34;

   // valid pipe: input stage, power row, quotient row, root row, two product
   // stages, step quotient row, output register
   localparam int LAT = 1 + POW_CELLS + DIV_CELLS + ROOT_CELLS + 2 + STEP_CELLS + 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_LR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_B1  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B2  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_EPS = 2'd3;

   // beta^t by square-and-multiply, one exponent bit per cell
   typedef struct packed {
      logic [CFG_W:0]    r1;
      logic [CFG_W-1:0]  b1;
      logic [CFG_W:0]    r2;
      logic [CFG_W-1:0]  b2;
      logic [STEP_W-1:0] t;
   } pow_type;

   // restoring divider, one quotient bit per cell
   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [QUO_W-1:0] bits;
      logic [QUO_W-1:0] quo;
      logic [DEN_W-1:0] den;
   } div_type;

   // digit-by-digit square root, one root bit per cell
   typedef struct packed {
      logic [QUO_W-1:0]  x;
      logic [REM2_W-1:0] rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [VAL_W-1:0]  cur;
      logic [VAL_W-1:0]  m;
      logic [MOM2_W-1:0] v;
   } side1_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] cur;
      logic             neg;
      logic             ovf;
   } side2_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] cur;
      logic             neg;
      logic [QUO_W-1:0] mhat;
   } side3_type;

   typedef struct packed {
      logic [IDX_W-1:0]   idx;
      logic [VAL_W-1:0]   cur;
      logic               neg;
      logic [DEN_W-1:0]   den;
      logic [2*CFG_W-1:0] ph;
      logic [2*CFG_W-1:0] pl;
   } prod_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] cur;
      logic             neg;
      logic [DEN_W-1:0] den;
      logic [QUO_W-1:0] p;
   } num_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [VAL_W-1:0] cur;
      logic             neg;
      logic             clamp;
   } side4_type;

endpackage

// ----- src/apu_pow_cell.sv -----
// One cell of the beta power chain: handles one bit of the step number.
module apu_pow_cell (
   input  logic             clock,
   input  logic             en,
   input  apu_pkg::pow_type pow_in,
   output apu_pkg::pow_type pow_out
);
   import apu_pkg::*;

   logic [2*CFG_W:0]   r1p;
   logic [2*CFG_W:0]   r2p;
   logic [2*CFG_W-1:0] b1p;
   logic [2*CFG_W-1:0] b2p;
   pow_type            nxt_in;
   pow_type            out_ff;

   // multiply result by base when the bit is set, square the base
   always_comb begin
      r1p = (2*CFG_W+1)'(pow_in.r1) * (2*CFG_W+1)'(pow_in.b1);
      r2p = (2*CFG_W+1)'(pow_in.r2) * (2*CFG_W+1)'(pow_in.b2);
      b1p = (2*CFG_W)'(pow_in.b1) * (2*CFG_W)'(pow_in.b1);
      b2p = (2*CFG_W)'(pow_in.b2) * (2*CFG_W)'(pow_in.b2);
      nxt_in.r1 = pow_in.t[0] ? r1p[2*CFG_W:CFG_W] : pow_in.r1;
      nxt_in.r2 = pow_in.t[0] ? r2p[2*CFG_W:CFG_W] : pow_in.r2;
      nxt_in.b1 = b1p[2*CFG_W-1:CFG_W];
      nxt_in.b2 = b2p[2*CFG_W-1:CFG_W];
      nxt_in.t  = pow_in.t >> 1;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= nxt_in;
      end
   end

   assign pow_out = out_ff;
endmodule

// ----- src/apu_div_cell.sv -----
// One cell of a restoring divider row: produces one quotient bit.
module apu_div_cell (
   input  logic             clock,
   input  logic             en,
   input  apu_pkg::div_type div_in,
   output apu_pkg::div_type div_out
);
   import apu_pkg::*;

   logic [DEN_W:0] rem_sh;
   logic [DEN_W:0] diff;
   logic           ge;
   div_type        nxt_in;
   div_type        out_ff;

   // shift in the next dividend bit, subtract when it fits
   always_comb begin
      rem_sh = {div_in.rem, div_in.bits[QUO_W-1]};
      ge     = rem_sh >= {1'b0, div_in.den};
      diff   = rem_sh - {1'b0, div_in.den};
      nxt_in.rem  = ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      nxt_in.bits = {div_in.bits[QUO_W-2:0], 1'b0};
      nxt_in.quo  = {div_in.quo[QUO_W-2:0], ge};
      nxt_in.den  = div_in.den;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= nxt_in;
      end
   end

   assign div_out = out_ff;
endmodule

// ----- src/apu_sqrt_cell.sv -----
// One cell of the square root row: produces one root bit.
module apu_sqrt_cell (
   input  logic              clock,
   input  logic              en,
   input  apu_pkg::sqrt_type sqrt_in,
   output apu_pkg::sqrt_type sqrt_out
);
   import apu_pkg::*;

   logic [REM2_W+1:0] rem_sh;
   logic [REM2_W+1:0] trial;
   logic [REM2_W+1:0] diff;
   logic              ge;
   sqrt_type          nxt_in;
   sqrt_type          out_ff;

   // bring in two radicand bits, try 4*root+1
   always_comb begin
      rem_sh = {sqrt_in.rem, sqrt_in.x[QUO_W-1:QUO_W-2]};
      trial  = (REM2_W+2)'({sqrt_in.root, 2'b01});
      ge     = rem_sh >= trial;
      diff   = rem_sh - trial;
      nxt_in.rem  = ge ? diff[REM2_W-1:0] : rem_sh[REM2_W-1:0];
      nxt_in.root = {sqrt_in.root[ROOT_W-2:0], ge};
      nxt_in.x    = {sqrt_in.x[QUO_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= nxt_in;
      end
   end

   assign sqrt_out = out_ff;
endmodule

// ----- src/adam_parameter_update.sv -----
// Top level of the Adam parameter update pipeline.
// Takes one request per cycle when not stalled and returns one result per
// request, in order: one input stage with the moment stores, a 16-cell power
// row for beta^t, a 64-cell quotient row for the corrected moments, a 32-cell
// square root row, two product stages, a 34-cell quotient row for the step
// and the output register. The whole pipe advances when the output register
// is empty or being taken. After reset a clearing pass zeroes both moment
// stores, with req_tready low; register writes are taken throughout. The user
// must write registers only while no request is in flight (not enforced).
module adam_parameter_update (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // element_index[11:0], gradient[43:12], current_value[75:44],
   // step_number[91:76], zero fill
   input  logic [95:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // result_index[11:0], new_value[43:12], zero fill
   output logic [47:0]                   rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [apu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [apu_pkg::CFG_W-1:0]     csr_wr_data
);
   import apu_pkg::*;

   localparam logic [CFG_W:0] ONE_Q32 = {1'b1, {CFG_W{1'b0}}};

   // configuration
   logic [CFG_W-1:0] lr_ff, b1_ff, b2_ff, eps_ff;

   // control
   logic             advance;
   logic             accept;
   logic             clr_ff;
   logic [SLOT_W-1:0] clr_cnt_ff;
   logic             vld_ff [LAT];
   logic             hit_ff;

   // input decode
   logic [IDX_W-1:0]  idx_in;
   logic [VAL_W-1:0]  g_in;
   logic [VAL_W-1:0]  cur_in;
   logic [STEP_W-1:0] t_in;
   logic [VAL_W-1:0]  gabs;
   logic [2*VAL_W-1:0] gsq;

   // input stage
   logic [IDX_W-1:0]  idx_ff;
   logic [VAL_W-1:0]  g_ff;
   logic [G2_W-1:0]   g2_ff;
   logic [VAL_W-1:0]  cur_ff;
   logic [STEP_W-1:0] t_ff;
   logic [VAL_W-1:0]  rd_m_ff;
   logic [MOM2_W-1:0] rd_v_ff;
   logic [VAL_W-1:0]  fwd_m_ff;
   logic [MOM2_W-1:0] fwd_v_ff;

   // moment stores
   logic [VAL_W-1:0]  m_mem [PARAM_COUNT];
   logic [MOM2_W-1:0] v_mem [PARAM_COUNT];
   logic              mem_we;
   logic [SLOT_W-1:0] mem_wa;
   logic [VAL_W-1:0]  mem_wm;
   logic [MOM2_W-1:0] mem_wv;

   // moment update
   logic [VAL_W-1:0]  m_old, m_new;
   logic [MOM2_W-1:0] v_old, v_new;
   logic [CFG_W:0]    c1w, c2w;
   logic [VAL_W:0]    dm;
   logic [66:0]       mprod;
   logic [VAL_W+1:0]  m_sum;
   logic [MOM2_W:0]   dv;
   logic [16:0]       dvh;
   logic [50:0]       hprod;
   logic [2*CFG_W:0]  lprod;
   logic [50:0]       vdelta;
   logic [50:0]       v_sum;

   // chains
   pow_type   pow_head;
   pow_type   pow_q [POW_CELLS];
   side1_type side1_ff [POW_CELLS];
   div_type   dm_head, dv_head;
   div_type   dm_q [DIV_CELLS];
   div_type   dv_q [DIV_CELLS];
   side2_type side2_head;
   side2_type side2_ff [DIV_CELLS];
   sqrt_type  sq_head;
   sqrt_type  sq_q [ROOT_CELLS];
   side3_type side3_head;
   side3_type side3_ff [ROOT_CELLS];
   prod_type  prod_in, prod_ff;
   num_type   num_in, num_ff;
   div_type   ds_head;
   div_type   ds_q [STEP_CELLS];
   side4_type side4_head;
   side4_type side4_ff [STEP_CELLS];

   // power row tail
   logic [CFG_W:0]  c1, c2;
   logic [VAL_W-1:0] mabs;
   logic [DEN_W-1:0] den_raw;

   // output
   logic [35:0]      step36, cur36, res36;
   logic [VAL_W-1:0] res_in;
   logic [IDX_W-1:0] rsp_idx_ff;
   logic [VAL_W-1:0] rsp_val_ff;

   // handshake
   assign advance    = !vld_ff[LAT-1] || rsp_tready;
   assign req_tready = advance && !clr_ff;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = vld_ff[LAT-1];
   assign rsp_tdata  = {4'b0000, rsp_val_ff, rsp_idx_ff};

   // request fields and gradient square
   always_comb begin
      idx_in = req_tdata[11:0];
      g_in   = req_tdata[43:12];
      cur_in = req_tdata[75:44];
      t_in   = (req_tdata[91:76] == '0) ? STEP_W'(1) : req_tdata[91:76];
      gabs   = g_in[VAL_W-1] ? (~g_in + VAL_W'(1)) : g_in;
      gsq    = (2*VAL_W)'(gabs) * (2*VAL_W)'(gabs);
   end

   // configuration registers, valid pipe, clearing pass
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff      <= CFG_W'(4294967);
         b1_ff      <= CFG_W'(32'd3865470566);
         b2_ff      <= CFG_W'(32'd4290672329);
         eps_ff     <= CFG_W'(43);
         clr_ff     <= 1'b1;
         clr_cnt_ff <= '0;
         hit_ff     <= 1'b0;
         for (int k = 0; k < LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_LR:  lr_ff  <= csr_wr_data;
               REG_B1:  b1_ff  <= csr_wr_data;
               REG_B2:  b2_ff  <= csr_wr_data;
               REG_EPS: eps_ff <= csr_wr_data;
               default: ;
            endcase
         end
         if (clr_ff) begin
            clr_cnt_ff <= clr_cnt_ff + SLOT_W'(1);
            if (clr_cnt_ff == SLOT_W'(PARAM_COUNT - 1)) begin
               clr_ff <= 1'b0;
            end
         end
         if (advance) begin
            vld_ff[0] <= accept;
            for (int k = 1; k < LAT; k++) begin
               vld_ff[k] <= vld_ff[k-1];
            end
            hit_ff <= vld_ff[0] && (idx_ff[SLOT_W-1:0] == idx_in[SLOT_W-1:0]);
         end
      end
   end

   // input stage payload and forwarded moments
   always_ff @(posedge clock) begin
      if (advance) begin
         idx_ff   <= idx_in;
         g_ff     <= g_in;
         g2_ff    <= gsq[G2_W+15:16];
         cur_ff   <= cur_in;
         t_ff     <= t_in;
         fwd_m_ff <= m_new;
         fwd_v_ff <= v_new;
      end
   end

   // moment stores: one write, one registered read
   assign mem_we = clr_ff || (advance && vld_ff[0]);
   assign mem_wa = clr_ff ? clr_cnt_ff : idx_ff[SLOT_W-1:0];
   assign mem_wm = clr_ff ? '0 : m_new;
   assign mem_wv = clr_ff ? '0 : v_new;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         m_mem[mem_wa] <= mem_wm;
         v_mem[mem_wa] <= mem_wv;
      end
      if (advance) begin
         rd_m_ff <= m_mem[idx_in[SLOT_W-1:0]];
         rd_v_ff <= v_mem[idx_in[SLOT_W-1:0]];
      end
   end

   // moment update: x + floor((target - x) * (1 - beta))
   always_comb begin
      m_old  = hit_ff ? fwd_m_ff : rd_m_ff;
      v_old  = hit_ff ? fwd_v_ff : rd_v_ff;
      c1w    = ONE_Q32 - {1'b0, b1_ff};
      c2w    = ONE_Q32 - {1'b0, b2_ff};
      dm     = {g_ff[VAL_W-1], g_ff} - {m_old[VAL_W-1], m_old};
      mprod  = {{34{dm[VAL_W]}}, dm} * {34'b0, c1w};
      m_sum  = {{2{m_old[VAL_W-1]}}, m_old} + mprod[65:32];
      m_new  = m_sum[VAL_W-1:0];
      dv     = {2'b00, g2_ff} - {1'b0, v_old};
      dvh    = dv[MOM2_W:32];
      hprod  = {{34{dvh[16]}}, dvh} * {18'b0, c2w};
      lprod  = (2*CFG_W+1)'(dv[31:0]) * (2*CFG_W+1)'(c2w);
      vdelta = hprod + {18'b0, lprod[2*CFG_W:CFG_W]};
      v_sum  = {3'b000, v_old} + vdelta;
      v_new  = v_sum[MOM2_W-1:0];
   end

   // beta^t chain
   assign pow_head = '{r1: ONE_Q32, b1: b1_ff, r2: ONE_Q32, b2: b2_ff, t: t_ff};

   for (genvar k = 0; k < POW_CELLS; k++) begin : g_pow
      if (k == 0) begin : g_first
         apu_pow_cell u_cell (
            .clock(clock), .en(advance), .pow_in(pow_head), .pow_out(pow_q[k]));
      end else begin : g_next
         apu_pow_cell u_cell (
            .clock(clock), .en(advance), .pow_in(pow_q[k-1]), .pow_out(pow_q[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side1_ff[0] <= '{idx: idx_ff, cur: cur_ff, m: m_new, v: v_new};
         for (int k = 1; k < POW_CELLS; k++) begin
            side1_ff[k] <= side1_ff[k-1];
         end
      end
   end

   // bias corrections and divider setup
   always_comb begin
      c1   = ONE_Q32 - pow_q[POW_CELLS-1].r1;
      c2   = ONE_Q32 - pow_q[POW_CELLS-1].r2;
      mabs = side1_ff[POW_CELLS-1].m[VAL_W-1] ?
             (~side1_ff[POW_CELLS-1].m + VAL_W'(1)) : side1_ff[POW_CELLS-1].m;
      dm_head = '{rem: '0, bits: {mabs, 32'b0}, quo: '0, den: {16'b0, c1}};
      dv_head = '{rem: {33'b0, side1_ff[POW_CELLS-1].v[MOM2_W-1:32]},
                  bits: {side1_ff[POW_CELLS-1].v[31:0], 32'b0},
                  quo: '0, den: {16'b0, c2}};
      side2_head.idx = side1_ff[POW_CELLS-1].idx;
      side2_head.cur = side1_ff[POW_CELLS-1].cur;
      side2_head.neg = side1_ff[POW_CELLS-1].m[VAL_W-1];
      side2_head.ovf = {17'b0, side1_ff[POW_CELLS-1].v[MOM2_W-1:32]} >= c2;
   end

   // corrected moment quotient rows
   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      if (k == 0) begin : g_first
         apu_div_cell u_m (
            .clock(clock), .en(advance), .div_in(dm_head), .div_out(dm_q[k]));
         apu_div_cell u_v (
            .clock(clock), .en(advance), .div_in(dv_head), .div_out(dv_q[k]));
      end else begin : g_next
         apu_div_cell u_m (
            .clock(clock), .en(advance), .div_in(dm_q[k-1]), .div_out(dm_q[k]));
         apu_div_cell u_v (
            .clock(clock), .en(advance), .div_in(dv_q[k-1]), .div_out(dv_q[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side2_ff[0] <= side2_head;
         for (int k = 1; k < DIV_CELLS; k++) begin
            side2_ff[k] <= side2_ff[k-1];
         end
      end
   end

   // square root of the corrected second moment, saturated on overflow
   always_comb begin
      sq_head.x    = side2_ff[DIV_CELLS-1].ovf ? '1 : dv_q[DIV_CELLS-1].quo;
      sq_head.rem  = '0;
      sq_head.root = '0;
      side3_head.idx  = side2_ff[DIV_CELLS-1].idx;
      side3_head.cur  = side2_ff[DIV_CELLS-1].cur;
      side3_head.neg  = side2_ff[DIV_CELLS-1].neg;
      side3_head.mhat = dm_q[DIV_CELLS-1].quo;
   end

   for (genvar k = 0; k < ROOT_CELLS; k++) begin : g_sqrt
      if (k == 0) begin : g_first
         apu_sqrt_cell u_cell (
            .clock(clock), .en(advance), .sqrt_in(sq_head), .sqrt_out(sq_q[k]));
      end else begin : g_next
         apu_sqrt_cell u_cell (
            .clock(clock), .en(advance), .sqrt_in(sq_q[k-1]), .sqrt_out(sq_q[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side3_ff[0] <= side3_head;
         for (int k = 1; k < ROOT_CELLS; k++) begin
            side3_ff[k] <= side3_ff[k-1];
         end
      end
   end

   // denominator and learning rate partial products
   always_comb begin
      den_raw = {1'b0, sq_q[ROOT_CELLS-1].root, 16'b0} + {17'b0, eps_ff};
      prod_in.idx = side3_ff[ROOT_CELLS-1].idx;
      prod_in.cur = side3_ff[ROOT_CELLS-1].cur;
      prod_in.neg = side3_ff[ROOT_CELLS-1].neg;
      prod_in.den = (den_raw == '0) ? DEN_W'(1) : den_raw;
      prod_in.ph  = (2*CFG_W)'(lr_ff) * (2*CFG_W)'(side3_ff[ROOT_CELLS-1].mhat[63:32]);
      prod_in.pl  = (2*CFG_W)'(lr_ff) * (2*CFG_W)'(side3_ff[ROOT_CELLS-1].mhat[31:0]);
   end

   // sum of partial products
   always_comb begin
      num_in.idx = prod_ff.idx;
      num_in.cur = prod_ff.cur;
      num_in.neg = prod_ff.neg;
      num_in.den = prod_ff.den;
      num_in.p   = prod_ff.ph + {32'b0, prod_ff.pl[63:32]};
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= prod_in;
         num_ff  <= num_in;
      end
   end

   // step quotient setup; a quotient of four or more clamps the step
   always_comb begin
      ds_head.rem  = num_ff.p[DEN_W+1:2];
      ds_head.bits = {num_ff.p[1:0], 62'b0};
      ds_head.quo  = '0;
      ds_head.den  = num_ff.den;
      side4_head.idx   = num_ff.idx;
      side4_head.cur   = num_ff.cur;
      side4_head.neg   = num_ff.neg;
      side4_head.clamp = num_ff.p >= {13'b0, num_ff.den, 2'b00};
   end

   for (genvar k = 0; k < STEP_CELLS; k++) begin : g_step
      if (k == 0) begin : g_first
         apu_div_cell u_cell (
            .clock(clock), .en(advance), .div_in(ds_head), .div_out(ds_q[k]));
      end else begin : g_next
         apu_div_cell u_cell (
            .clock(clock), .en(advance), .div_in(ds_q[k-1]), .div_out(ds_q[k]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side4_ff[0] <= side4_head;
         for (int k = 1; k < STEP_CELLS; k++) begin
            side4_ff[k] <= side4_ff[k-1];
         end
      end
   end

   // apply step against the sign of the first moment, saturate
   always_comb begin
      step36 = side4_ff[STEP_CELLS-1].clamp ? {2'b01, 34'b0} :
               {2'b00, ds_q[STEP_CELLS-1].quo[33:0]};
      cur36  = {{4{side4_ff[STEP_CELLS-1].cur[VAL_W-1]}}, side4_ff[STEP_CELLS-1].cur};
      res36  = side4_ff[STEP_CELLS-1].neg ? (cur36 + step36) : (cur36 - step36);
      if (res36[35:31] == 5'b00000 || res36[35:31] == 5'b11111) begin
         res_in = res36[VAL_W-1:0];
      end else if (res36[35]) begin
         res_in = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         res_in = {1'b0, {(VAL_W-1){1'b1}}};
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_idx_ff <= side4_ff[STEP_CELLS-1].idx;
         rsp_val_ff <= res_in;
      end
   end
endmodule

// ----- tb/tb_adam_parameter_update.sv -----
// Self-checking testbench for the Adam parameter update pipeline.
`timescale 1ns / 1ps

module tb_adam_parameter_update;
   import apu_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 500;
   localparam int HOLD_AT_RESULT = 1000;

   typedef struct {
      logic [IDX_W-1:0]         idx;
      logic signed [VAL_W-1:0]  grad;
      logic signed [VAL_W-1:0]  cur;
      logic [STEP_W-1:0]        step;
   } update_req_type;

   typedef struct {
      logic [IDX_W-1:0]         idx;
      logic signed [VAL_W-1:0]  value;
   } update_rsp_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [47:0] rsp_tdata;
   logic csr_wr_en = 0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   adam_parameter_update uut (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // predictor state: register copies and moment stores
   logic [31:0] lr_q, beta1_q, beta2_q, eps_q;
   logic signed [31:0] first_mom [PARAM_COUNT];
   logic [47:0] second_mom [PARAM_COUNT];

   update_req_type pending_reqs[$];
   update_rsp_type expected_updates[$];
   update_req_type offered;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int errors = 0;
   int reqs_sent = 0;
   int rsps_seen = 0;
   int clamp_seen = 0;
   int hold_left = 0;
   int idle_cycles = 0;

   // floor(a*b/2^32), signed a
   function automatic longint scale_q32(input longint a, input logic [32:0] b);
      logic signed [127:0] prod;
      prod = $signed({{64{a[63]}}, a}) * $signed({95'd0, b});
      return longint'(prod >>> 32);
   endfunction

   // beta^t, truncating Q0.32 square-and-multiply
   function automatic logic [63:0] beta_power(input logic [31:0] beta, input logic [15:0] t);
      logic [63:0] r, b;
      r = 64'h1_0000_0000;
      b = {32'd0, beta};
      while (t != 0) begin
         if (t[0]) r = (r * b) >> 32;
         b = (b * b) >> 32;
         t = t >> 1;
      end
      return r;
   endfunction

   function automatic logic [63:0] int_sqrt(input logic [63:0] x);
      logic [63:0] r, b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // updates the moments of one element and returns its new value
   function automatic update_rsp_type adam_new_value(input update_req_type rq);
      update_rsp_type rs;
      logic [11:0] slot;
      logic [15:0] t;
      longint g, m, sum, res;
      logic [63:0] g2, v, c1, c2, mabs, mhat, hi, rem, vhat, den, mh, ml, p, q, r, step;
      slot = rq.idx;
      t = (rq.step == 0) ? 16'd1 : rq.step;
      g = longint'(rq.grad);
      m = longint'(first_mom[slot]);
      m = m + scale_q32(g - m, 33'(64'h1_0000_0000 - beta1_q));
      first_mom[slot] = m[31:0];
      g2 = 64'(g * g) >> 16;
      v = {16'd0, second_mom[slot]};
      sum = longint'(v) + scale_q32(longint'(g2) - longint'(v), 33'(64'h1_0000_0000 - beta2_q));
      v = {16'd0, sum[47:0]};
      second_mom[slot] = v[47:0];
      c1 = 64'h1_0000_0000 - beta_power(beta1_q, t);
      c2 = 64'h1_0000_0000 - beta_power(beta2_q, t);
      mabs = (m < 0) ? 64'(-m) : 64'(m);
      mhat = (mabs << 32) / c1;
      hi = v / c2;
      rem = v % c2;
      vhat = (hi >= 64'h1_0000_0000) ? '1 : (hi << 32) + ((rem << 32) / c2);
      den = (int_sqrt(vhat) << 16) + {32'd0, eps_q};
      if (den == 0) den = 1;
      mh = mhat >> 32;
      ml = {32'd0, mhat[31:0]};
      p = {32'd0, lr_q} * mh + (({32'd0, lr_q} * ml) >> 32);
      q = p / den;
      r = p % den;
      if (q >= 4) begin
         step = 64'd1 << 34;
         clamp_seen++;
      end else begin
         for (int i = 0; i < 32; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
               r = r - den;
               q[0] = 1'b1;
            end
         end
         step = q;
      end
      res = (m < 0) ? longint'(rq.cur) + longint'(step) : longint'(rq.cur) - longint'(step);
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      rs.idx = rq.idx;
      rs.value = res[31:0];
      return rs;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_updates.push_back(adam_new_value(offered));
            reqs_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered = pending_reqs.pop_front();
               req_tdata <= {4'd0, offered.step, offered.cur, offered.grad, offered.idx};
               req_tvalid <= 1;
            end else begin
               req_tvalid <= 0;
            end
         end
      end
   end

   // result monitor, with one long hold-off
   always @(posedge clock) begin
      update_rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            rsps_seen++;
            if (expected_updates.size() == 0) begin
               $display("%0t unexpected result: actual idx=%0d value=%0d", $time,
                        rsp_tdata[11:0], $signed(rsp_tdata[43:12]));
               errors++;
            end else begin
               exp_rsp = expected_updates.pop_front();
               if (rsp_tdata[11:0] !== exp_rsp.idx) begin
                  $display("%0t result_index mismatch: expected %0d actual %0d", $time,
                           exp_rsp.idx, rsp_tdata[11:0]);
                  errors++;
               end
               if (rsp_tdata[43:12] !== exp_rsp.value) begin
                  $display("%0t new_value mismatch (idx %0d): expected %0d actual %0d", $time,
                           exp_rsp.idx, exp_rsp.value, $signed(rsp_tdata[43:12]));
                  errors++;
               end
            end
            if (rsps_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wr_data <= data;
      @(posedge clock);
      csr_wr_en <= 0;
      case (idx)
         REG_LR:  lr_q = data;
         REG_B1:  beta1_q = data;
         REG_B2:  beta2_q = data;
         default: eps_q = data;
      endcase
   endtask

   task automatic set_regs(input logic [31:0] lr, b1, b2, eps);
      write_reg(REG_LR, lr);
      write_reg(REG_B1, b1);
      write_reg(REG_B2, b2);
      write_reg(REG_EPS, eps);
   endtask

   task automatic add_req(input logic [11:0] idx, input logic [31:0] g, cur,
                          input logic [15:0] t);
      update_req_type rq;
      rq.idx = idx;
      rq.grad = g;
      rq.cur = cur;
      rq.step = t;
      pending_reqs.push_back(rq);
   endtask

   // sender pauses until every expected result is back
   task automatic drain();
      wait (pending_reqs.size() == 0 && !req_tvalid && expected_updates.size() == 0);
      repeat (LAT + 10) @(posedge clock);
   endtask

   // mostly training sequences on a small set of elements, some noise
   task automatic add_random_reqs(input int count);
      logic [11:0] pool [24];
      logic [15:0] steps [24];
      logic [31:0] g, cur;
      int k;
      foreach (pool[i]) begin
         pool[i] = 12'($urandom_range(4095));
         steps[i] = ($urandom_range(3) == 0) ? 16'($urandom_range(65000)) : 16'd0;
      end
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) < 85) begin
            k = $urandom_range(23);
            steps[k]++;
            g = $urandom >>> $urandom_range(24);
            if ($urandom_range(1)) g = -g;
            cur = $urandom >>> $urandom_range(8);
            add_req(pool[k], g, cur, steps[k]);
         end else begin
            add_req(12'($urandom_range(4095)), $urandom, $urandom,
                    16'($urandom_range(65535)));
         end
      end
   endtask

   initial begin
      foreach (first_mom[i]) begin
         first_mom[i] = 0;
         second_mom[i] = 0;
      end
      lr_q = 32'd4294967;
      beta1_q = 32'd3865470566;
      beta2_q = 32'd4290672329;
      eps_q = 32'd43;
      repeat (9) @(posedge clock);
      reset <= 0;

      // defaults, field extremes and step zero
      set_regs(32'd4294967, 32'd3865470566, 32'd4290672329, 32'd43);
      add_req(12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd1);
      add_req(12'd4095, 32'h8000_0000, 32'h7FFF_FFFF, 16'd65535);
      add_req(12'd9, 32'h0100_0000, 32'd0, 16'd0);
      add_req(12'd9, 32'h0100_0000, 32'd0, 16'd2);
      add_req(12'd9, 32'hFF00_0000, 32'h0080_0000, 16'd3);
      add_req(12'd9, 32'd0, 32'd0, 16'd4);
      add_req(12'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'd2);
      add_req(12'd2730, 32'h5555_5555, 32'hAAAA_AAAA, 16'hAAAA);
      add_req(12'd1365, 32'hAAAA_AAAA, 32'h5555_5555, 16'h5555);
      drain();

      // zero denominator and huge step
      set_regs(32'hFFFF_FFFF, 32'd0, 32'd0, 32'd0);
      add_req(12'd100, 32'd200, 32'd0, 16'd1);
      add_req(12'd101, 32'd0, 32'd12345, 16'd1);
      add_req(12'd102, -32'sd200, 32'h7FFF_0000, 16'd1);
      add_req(12'd103, 32'h7FFF_FFFF, 32'h8000_0000, 16'd5);
      add_req(12'd100, 32'd100, 32'h8000_0000, 16'd2);
      drain();

      // betas and epsilon at their top
      set_regs(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      add_req(12'd200, 32'h7FFF_FFFF, 32'd77, 16'd1);
      add_req(12'd200, 32'h8000_0000, 32'd77, 16'd65535);
      drain();
      write_reg(REG_LR, 32'h8000_0000);
      add_req(12'd201, 32'h0001_0000, 32'd0, 16'd1);
      add_req(12'd201, 32'hFFFF_0000, 32'd0, 16'd2);
      drain();

      // random phase, sender seldom idle, receiver often
      sender_idle_pct = 9;
      receiver_idle_pct = 70;
      set_regs(32'd4294967, 32'd3865470566, 32'd4290672329, 32'd43);
      add_random_reqs(400);
      drain();

      sender_idle_pct = 70;
      receiver_idle_pct = 9;
      set_regs($urandom, $urandom_range(32'hFFFF_FFFF, 32'hC000_0000),
               $urandom_range(32'hFFFF_FFFF, 32'hF000_0000), $urandom_range(1000));
      add_random_reqs(400);
      drain();

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      set_regs($urandom_range(32'h0100_0000), $urandom, $urandom, $urandom_range(3));
      add_random_reqs(400);
      drain();

      $display("covered %0d requests, %0d results, %0d clamped steps, over six settings",
               reqs_sent, rsps_seen, clamp_seen);
      if (errors == 0 && expected_updates.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches, %0d results missing", errors, expected_updates.size());
         $display("status: fail");
      end
      $finish;
   end

endmodule
